/* rtl/core/sk64_pkg.sv */
package sk64_pkg;

  // block and key geometry
  localparam int BLOCK_W        = 64;
  localparam int KEY_W          = 32;
  localparam int CELLS          = 16;
  localparam int KEY_CELLS      = 8;
  localparam int NUM_KEYS       = 6;
  localparam int ROUNDS_DEFAULT = 6;

  // config port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int KEY_IDX_W  = 3;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   rkey_t;

  // 4-bit s-box
  localparam logic [3:0] SBOX [CELLS] = '{
    4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
    4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
  };

  // one full round: s-box, key into rows 0 and 1, row rotate, column mix
  // cell k sits at nibble k counted from the top of the word
  function automatic block_t round_fn(input block_t x, input rkey_t k);
    logic [3:0] c [CELLS];
    logic [3:0] t [CELLS];
    logic [1:0] dst;
    block_t     y;
    // substitute every cell
    for (int i = 0; i < CELLS; i++) begin
      c[i] = SBOX[x[BLOCK_W-1-4*i -: 4]];
    end
    // round key covers the top two rows
    for (int i = 0; i < KEY_CELLS; i++) begin
      c[i] = c[i] ^ k[KEY_W-1-4*i -: 4];
    end
    // row r rotates right by r cells
    for (int r = 0; r < 4; r++) begin
      for (int col = 0; col < 4; col++) begin
        dst = 2'(col + r);
        t[4*r + int'(dst)] = c[4*r + col];
      end
    end
    // binary mix of each column
    for (int col = 0; col < 4; col++) begin
      c[col]      = t[col] ^ t[8+col] ^ t[12+col];
      c[4+col]    = t[col];
      c[8+col]    = t[4+col] ^ t[8+col];
      c[12+col]   = t[col] ^ t[8+col];
    end
    for (int i = 0; i < CELLS; i++) begin
      y[BLOCK_W-1-4*i -: 4] = c[i];
    end
    return y;
  endfunction

endpackage

/* rtl/core/sk64_round_cell.sv */
// one round stage of the cipher chain: holds one block, hands it on each cycle while out_ready is high
module sk64_round_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sk64_pkg::block_t  in_data,
  output logic              in_ready,
  input  sk64_pkg::rkey_t   key,
  output logic              out_valid,
  output sk64_pkg::block_t  out_data,
  input  logic              out_ready
);

  logic             valid;
  sk64_pkg::block_t data;

  // stage takes a new block when empty or when its block moves on
  assign in_ready = !valid || out_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // round result
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= sk64_pkg::round_fn(in_data, key);
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

/* rtl/core/skinny64_reduced_round_encrypt.sv */
// Reduced-round SKINNY-64 style encryption of one 64-bit block per beat, with
// no round constants and one key per round taken from the round_key registers
// (byte address 4*i for round i, rows 0 and 1 as eight nibbles, row 0 column 0
// in bits 31..28; rounds past NUM_KEYS use a zero key). Each round is one
// register stage in a chain of ROUNDS identical cells, and a new block can
// enter every cycle; throughput is one block per clock as long as m_tready
// stays high. A stall holds the output cell and every occupied cell behind it
// up to the first empty one, which still takes a new block.
// Keys must only be written while no block is in flight.
module skinny64_reduced_round_encrypt #(
  parameter int ROUNDS = sk64_pkg::ROUNDS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sk64_pkg::BLOCK_W-1:0]    s_tdata,   // [63:0] plaintext
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sk64_pkg::BLOCK_W-1:0]    m_tdata,   // [63:0] ciphertext
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sk64_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sk64_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sk64_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  sk64_pkg::rkey_t                round_key [sk64_pkg::NUM_KEYS];
  logic [sk64_pkg::KEY_IDX_W-1:0] key_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign key_idx = paddr[sk64_pkg::KEY_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // key registers, writes past the last key are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sk64_pkg::NUM_KEYS; i++) begin
        round_key[i] <= '0;
      end
    end else if (cfg_wr && (int'(key_idx) < sk64_pkg::NUM_KEYS)) begin
      round_key[key_idx] <= pwdata;
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (int'(key_idx) < sk64_pkg::NUM_KEYS) begin
      prdata = round_key[key_idx];
    end
  end

  // chain links: link 0 is the input port, link ROUNDS the output
  logic             link_valid [ROUNDS+1];
  logic             link_ready [ROUNDS+1];
  sk64_pkg::block_t link_data  [ROUNDS+1];

  assign link_valid[0]      = s_tvalid;
  assign link_data[0]       = s_tdata;
  assign s_tready           = link_ready[0];
  assign link_ready[ROUNDS] = m_tready;
  assign m_tvalid           = link_valid[ROUNDS];
  assign m_tdata            = link_data[ROUNDS];

  // one cell per round
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    sk64_pkg::rkey_t cell_key;
    if (g < sk64_pkg::NUM_KEYS) begin : g_key
      assign cell_key = round_key[g];
    end else begin : g_zero
      assign cell_key = '0;
    end

    sk64_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_data   (link_data[g]),
      .in_ready  (link_ready[g]),
      .key       (cell_key),
      .out_valid (link_valid[g+1]),
      .out_data  (link_data[g+1]),
      .out_ready (link_ready[g+1])
    );
  end

endmodule

/* rtl/core/sk64_checker.sv */
// port-level checks on the encrypt block
module sk64_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [sk64_pkg::BLOCK_W-1:0] m_tdata
);

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a chain with a free output slot always takes input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled while output side can drain");

  // stalled output beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output beat dropped under stall");

  // stalled output beat keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("output data changed under stall");

endmodule

bind skinny64_reduced_round_encrypt sk64_checker u_sk64_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/skinny64_cipher_checker.sv */
module skinny64_cipher_checker #(
  parameter int ROUNDS = sk64_pkg::ROUNDS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // plaintext channel
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  sk64_pkg::block_t                s_tdata,   // [63:0] plaintext
  // ciphertext channel
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  sk64_pkg::block_t                m_tdata,   // [63:0] ciphertext
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sk64_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sk64_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [sk64_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  // status toward the testbench top
  output int                              mismatches,
  output int                              in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import sk64_pkg::*;

  // substitution table of the cipher
  localparam logic [3:0] SUBST [16] = '{
    4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
    4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
  };

  rkey_t  round_keys [NUM_KEYS];
  block_t expected_ct [$];

  // ciphertext of one block under the current round keys
  function automatic block_t encrypt_block(input block_t pt);
    logic [3:0] grid [4][4];
    logic [3:0] rot  [4][4];
    rkey_t      rk;
    block_t     ct;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        grid[r][c] = pt[63 - 4*(4*r + c) -: 4];
      end
    end
    for (int n = 0; n < ROUNDS; n++) begin
      rk = (n < NUM_KEYS) ? round_keys[n] : '0;
      // substitute, then key into the top two rows
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          grid[r][c] = SUBST[grid[r][c]];
          if (r < 2) begin
            grid[r][c] = grid[r][c] ^ rk[31 - 4*(4*r + c) -: 4];
          end
        end
      end
      // row r moves right by r cells
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          rot[r][(c + r) % 4] = grid[r][c];
        end
      end
      // column mix
      for (int c = 0; c < 4; c++) begin
        grid[0][c] = rot[0][c] ^ rot[2][c] ^ rot[3][c];
        grid[1][c] = rot[0][c];
        grid[2][c] = rot[1][c] ^ rot[2][c];
        grid[3][c] = rot[0][c] ^ rot[2][c];
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ct[63 - 4*(4*r + c) -: 4] = grid[r][c];
      end
    end
    return ct;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // watch both channels and the register port at every rising edge
  always @(posedge clk) begin
    int     idx;
    block_t want;
    if (rst) begin
      expected_ct.delete();
      for (int i = 0; i < NUM_KEYS; i++) begin
        round_keys[i] = '0;
      end
    end else begin
      // register writes and reads
      if (psel && penable && pready) begin
        idx = int'(paddr >> 2);
        if (idx < NUM_KEYS) begin
          if (pwrite) begin
            round_keys[idx] = pwdata;
          end else if (prdata !== round_keys[idx]) begin
            note_mismatch($sformatf("round_key_%0d read", idx), 64'(round_keys[idx]),
                          64'(prdata));
          end
        end
      end
      // plaintext beat: predict its ciphertext now
      if (s_tvalid && s_tready) begin
        expected_ct.push_back(encrypt_block(s_tdata));
      end
      // ciphertext beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_ct.size() == 0) begin
          note_mismatch("ciphertext beat with no block in flight", 'x, m_tdata);
        end else begin
          want = expected_ct.pop_front();
          if (m_tdata !== want) begin
            note_mismatch("ciphertext", want, m_tdata);
          end
        end
      end
    end
    in_flight = expected_ct.size();
  end

endmodule

/* test/tb_skinny64_reduced_round_encrypt.sv */
module tb_skinny64_reduced_round_encrypt;
  timeunit 1ns;
  timeprecision 1ps;
  import sk64_pkg::*;

  localparam int ROUNDS           = ROUNDS_DEFAULT;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int PHASES           = 10;
  localparam int BLOCKS_PER_PHASE = 115;

  localparam block_t CORNER_BLOCKS [8] = '{
    64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
    64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
    64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001
  };

  typedef enum int {
    RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD, RX_STARVED
  } rx_mode_e;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  block_t                s_tdata;   // [63:0] plaintext
  logic                  m_tvalid;
  logic                  m_tready;
  block_t                m_tdata;   // [63:0] ciphertext
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int in_flight;
  int cycles;
  int burst_left;

  skinny64_reduced_round_encrypt #(.ROUNDS(ROUNDS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  skinny64_cipher_checker #(.ROUNDS(ROUNDS)) ct_monitor (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ciphertext side: ready follows one of five patterns, each held for a random run and then drawn anew
  initial begin
    rx_mode_e rx_mode;
    int       rx_tick;
    m_tready = 1'b0;
    rx_tick  = 0;
    forever begin
      rx_mode = rx_mode_e'($urandom_range(0, 4));
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        case (rx_mode)
          RX_OPEN:        m_tready = 1'b1;
          RX_COIN:        m_tready = 1'($urandom_range(0, 1));
          RX_MOSTLY:      m_tready = ($urandom_range(0, 4) != 0);
          RX_EVERY_THIRD: m_tready = (rx_tick % 3 == 0);
          default:        m_tready = ($urandom_range(0, 15) == 0);
        endcase
        rx_tick++;
      end
    end
  end

  // register write, setup then access
  task automatic cfg_write(input int idx, input rkey_t val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(idx * 4);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // register read, value checked by the monitor
  task automatic cfg_read(input int idx);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = APB_ADDR_W'(idx * 4);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // one plaintext beat; valid stays high inside a burst
  task automatic send_block(input block_t pt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid = 1'b1;
    s_tdata  = pt;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // stop sending and wait for every ciphertext, then let the pipeline settle
  task automatic drain();
    s_tvalid   = 1'b0;
    burst_left = 0;
    while (in_flight != 0) @(negedge clk);
    repeat (ROUNDS + 2) @(negedge clk);
  endtask

  initial begin
    rkey_t  rk;
    block_t pt;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // keys straight out of reset
    for (int i = 0; i < NUM_KEYS; i++) cfg_read(i);
    foreach (CORNER_BLOCKS[i]) send_block(CORNER_BLOCKS[i]);
    drain();

    // all-ones keys; writes past the key list must leave the keys alone
    for (int i = 0; i < NUM_KEYS; i++) cfg_write(i, '1);
    cfg_write(NUM_KEYS, 32'h1234_5678);
    cfg_write(NUM_KEYS + 1, '0);
    for (int i = 0; i < NUM_KEYS; i++) cfg_read(i);
    foreach (CORNER_BLOCKS[i]) send_block(CORNER_BLOCKS[i]);
    drain();

    // random phases, each under a fresh key setting
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        case (ph % 5)
          0:       rk = '0;
          1:       rk = '1;
          2:       rk = rkey_t'(1) << $urandom_range(0, KEY_W - 1);
          3:       rk = ~(rkey_t'(1) << $urandom_range(0, KEY_W - 1));
          default: rk = $urandom;
        endcase
        cfg_write(i, rk);
      end
      if (ph % 2 == 1) cfg_write(NUM_KEYS + $urandom_range(0, 1), $urandom);
      for (int i = 0; i < NUM_KEYS; i++) cfg_read(i);

      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0:       pt = 64'(1) << $urandom_range(0, BLOCK_W - 1);
          1:       pt = ~(64'(1) << $urandom_range(0, BLOCK_W - 1));
          2:       pt = {16{4'($urandom_range(0, 15))}};
          3:       pt = CORNER_BLOCKS[$urandom_range(0, 7)];
          default: pt = {$urandom, $urandom};
        endcase
        send_block(pt);
        // hold off until the pipeline is empty now and then
        if (n == BLOCKS_PER_PHASE / 2 && ph % 3 == 0) begin
          s_tvalid   = 1'b0;
          burst_left = 0;
          while (in_flight != 0) @(negedge clk);
        end
      end
      drain();
    end

    repeat (ROUNDS + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
